// ===== rtl/jsm_pkg.sv =====
`default_nettype none

package jsm_pkg;

	// sample and register widths
	localparam int SAMPLE_BITS = 12;
	localparam int CFG_W       = 12;
	localparam int TIMEOUT_W   = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int PULSE_W     = 13;
	localparam int IDLE_W      = 16;
	localparam int PROD_W      = SAMPLE_BITS + CFG_W;

	// stream payload widths, rounded up to whole bytes
	localparam int IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((2 * PULSE_W + 7) / 8) * 8;
	localparam int OUT_USER_W  = 2;

	// full-scale sample code, the divisor of the pulse scaling
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = {SAMPLE_BITS{1'b1}};

	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

	// reset values
	localparam logic [CFG_W-1:0]     NOISE_THR_RST  = CFG_W'(200);
	localparam logic [TIMEOUT_W-1:0] IDLE_TMO_RST   = TIMEOUT_W'(1000);
	localparam logic [CFG_W-1:0]     X_MIN_RST      = CFG_W'(1300);
	localparam logic [CFG_W-1:0]     X_SPAN_RST     = CFG_W'(1100);
	localparam logic [CFG_W-1:0]     Y_MIN_RST      = CFG_W'(900);
	localparam logic [CFG_W-1:0]     Y_SPAN_RST     = CFG_W'(550);
	localparam logic [PULSE_W-1:0]   SERVO_RST      = PULSE_W'(1500);

	// item kinds
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_NOISE_THR = 3'd0,
		REG_IDLE_TMO  = 3'd1,
		REG_X_MIN     = 3'd2,
		REG_X_SPAN    = 3'd3,
		REG_Y_MIN     = 3'd4,
		REG_Y_SPAN    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0]     noise_thr;
		logic [TIMEOUT_W-1:0] idle_tmo;
		logic [CFG_W-1:0]     x_min;
		logic [CFG_W-1:0]     x_span;
		logic [CFG_W-1:0]     y_min;
		logic [CFG_W-1:0]     y_span;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/joystick_servo_mapper.sv =====
// each item passes the input register and then the result register; an output stall holds both
// throughput: one item per cycle while results are taken, input and result register both flow
// the span multiply sits before the input register, the divide and state update after it
// arst_n clears the state registers to their defaults, no reference loaded, manual mode off
// and both servo pulses at 1500
`default_nettype none

module joystick_servo_mapper (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// sample_x, sample_y
	input  wire logic [jsm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// opcode
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// pulse_x, pulse_y
	output logic      [jsm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// manual_mode, moved
	output logic      [jsm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	input  wire logic                                cfg_we,
	input  wire logic [jsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [jsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int N = jsm_pkg::SAMPLE_BITS;

	jsm_pkg::cfg_t cfg;

	logic [N-1:0]                in_x;
	logic [N-1:0]                in_y;

	logic                        valid_s1;
	logic                        op_s1;
	logic [N-1:0]                x_s1;
	logic [N-1:0]                y_s1;
	logic [jsm_pkg::PROD_W-1:0]  prod_x_s1;
	logic [jsm_pkg::PROD_W-1:0]  prod_y_s1;

	logic [N-1:0]                ref_x_q;
	logic [N-1:0]                ref_y_q;
	logic                        primed_q;
	logic                        manual_q;
	logic [jsm_pkg::IDLE_W-1:0]  idle_q;
	logic [jsm_pkg::PULSE_W-1:0] servo_x_q;
	logic [jsm_pkg::PULSE_W-1:0] servo_y_q;

	logic                        out_valid_q;
	logic                        out_moved_q;
	logic                        out_manual_q;

	logic                        in_fire;
	logic                        adv;
	logic [N-1:0]                diff_x;
	logic [N-1:0]                diff_y;
	logic                        mv_x;
	logic                        mv_y;
	logic                        mv;
	logic [jsm_pkg::PULSE_W-1:0] pulse_x_new;
	logic [jsm_pkg::PULSE_W-1:0] pulse_y_new;
	logic [jsm_pkg::IDLE_W-1:0]  idle_inc;

	jsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign in_x = s_axis_tdata[N-1:0];
	assign in_y = s_axis_tdata[2*N-1:N];

	// handshake: input stage moves on whenever the result register is free or drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// input register with the span products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= s_axis_tuser;
			x_s1      <= in_x;
			y_s1      <= in_y;
			prod_x_s1 <= jsm_pkg::PROD_W'(in_x) * jsm_pkg::PROD_W'(cfg.x_span);
			prod_y_s1 <= jsm_pkg::PROD_W'(in_y) * jsm_pkg::PROD_W'(cfg.y_span);
		end
	end

	// movement detection against the per-axis reference
	always_comb begin
		diff_x = (x_s1 >= ref_x_q) ? (x_s1 - ref_x_q) : (ref_x_q - x_s1);
		diff_y = (y_s1 >= ref_y_q) ? (y_s1 - ref_y_q) : (ref_y_q - y_s1);
		mv_x   = 32'(diff_x) > 32'(cfg.noise_thr);
		mv_y   = 32'(diff_y) > 32'(cfg.noise_thr);
		mv     = (op_s1 == jsm_pkg::OP_SAMPLE) && primed_q && (mv_x || mv_y);
		idle_inc = (idle_q < jsm_pkg::IDLE_MAX) ? (idle_q + jsm_pkg::IDLE_W'(1)) : idle_q;
	end

	jsm_scale u_scale_x (
		.prod  (prod_x_s1),
		.lo    (cfg.x_min),
		.span  (cfg.x_span),
		.pulse (pulse_x_new)
	);

	jsm_scale u_scale_y (
		.prod  (prod_y_s1),
		.lo    (cfg.y_min),
		.span  (cfg.y_span),
		.pulse (pulse_y_new)
	);

	// block state, updated as each item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q   <= '0;
			ref_y_q   <= '0;
			primed_q  <= 1'b0;
			manual_q  <= 1'b0;
			idle_q    <= '0;
			servo_x_q <= jsm_pkg::SERVO_RST;
			servo_y_q <= jsm_pkg::SERVO_RST;
		end else if (adv) begin
			if (op_s1 == jsm_pkg::OP_SAMPLE) begin
				if (!primed_q) begin
					ref_x_q  <= x_s1;
					ref_y_q  <= y_s1;
					primed_q <= 1'b1;
					idle_q   <= '0;
				end else if (mv) begin
					if (mv_x) begin
						ref_x_q <= x_s1;
					end
					if (mv_y) begin
						ref_y_q <= y_s1;
					end
					manual_q  <= 1'b1;
					idle_q    <= '0;
					servo_x_q <= pulse_x_new;
					servo_y_q <= pulse_y_new;
				end
			end else if (manual_q) begin
				idle_q <= idle_inc;
				if (32'(idle_inc) > 32'(cfg.idle_tmo)) begin
					manual_q <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_moved_q  <= mv;
			if (mv) begin
				out_manual_q <= 1'b1;
			end else if ((op_s1 == jsm_pkg::OP_TICK) && manual_q) begin
				out_manual_q <= !(32'(idle_inc) > 32'(cfg.idle_tmo));
			end else begin
				out_manual_q <= manual_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_moved_q, out_manual_q};
	assign m_axis_tdata  = jsm_pkg::OUT_DATA_W'({servo_y_q, servo_x_q});

`ifndef SYNTH
	// a moving sample always reports manual mode
	a_moved_manual: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("moved result without manual mode");

	// movement is only possible once the references are loaded
	a_moved_primed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> primed_q)
		else $error("moved result before priming");

	// input held off only while both stages are full and the output stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without back-pressure");

	// the reported mode tracks the mode register
	a_mode_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tuser[0] == manual_q)
		else $error("reported mode differs from state");
`endif

endmodule

`default_nettype wire

// ===== rtl/jsm_cfg.sv =====
`default_nettype none

module jsm_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [jsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [jsm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output jsm_pkg::cfg_t                            cfg
);

	jsm_pkg::cfg_t cfg_q;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_thr <= jsm_pkg::NOISE_THR_RST;
			cfg_q.idle_tmo  <= jsm_pkg::IDLE_TMO_RST;
			cfg_q.x_min     <= jsm_pkg::X_MIN_RST;
			cfg_q.x_span    <= jsm_pkg::X_SPAN_RST;
			cfg_q.y_min     <= jsm_pkg::Y_MIN_RST;
			cfg_q.y_span    <= jsm_pkg::Y_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				jsm_pkg::REG_NOISE_THR: cfg_q.noise_thr <= cfg_wdata[jsm_pkg::CFG_W-1:0];
				jsm_pkg::REG_IDLE_TMO:  cfg_q.idle_tmo  <= cfg_wdata[jsm_pkg::TIMEOUT_W-1:0];
				jsm_pkg::REG_X_MIN:     cfg_q.x_min     <= cfg_wdata[jsm_pkg::CFG_W-1:0];
				jsm_pkg::REG_X_SPAN:    cfg_q.x_span    <= cfg_wdata[jsm_pkg::CFG_W-1:0];
				jsm_pkg::REG_Y_MIN:     cfg_q.y_min     <= cfg_wdata[jsm_pkg::CFG_W-1:0];
				jsm_pkg::REG_Y_SPAN:    cfg_q.y_span    <= cfg_wdata[jsm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/jsm_scale.sv =====
`default_nettype none

module jsm_scale (
	input  wire logic [jsm_pkg::PROD_W-1:0]  prod,
	input  wire logic [jsm_pkg::CFG_W-1:0]   lo,
	input  wire logic [jsm_pkg::CFG_W-1:0]   span,
	output logic      [jsm_pkg::PULSE_W-1:0] pulse
);

	localparam int N  = jsm_pkg::SAMPLE_BITS;
	localparam int W  = jsm_pkg::PROD_W + 1;
	localparam int QW = W - N;

	localparam logic [W-1:0] FULL1 = W'(jsm_pkg::SAMPLE_FULL);
	localparam logic [W-1:0] FULL2 = W'(2 * int'(jsm_pkg::SAMPLE_FULL));

	logic [W-1:0]               est_sum;
	logic [QW-1:0]              q_est;
	logic [W-1:0]               q_times_full;
	logic [W-1:0]               rem;
	logic [QW-1:0]              quot;
	logic [jsm_pkg::PULSE_W-1:0] raw;
	logic [jsm_pkg::PULSE_W-1:0] top;

	// divide by 2^n-1: estimate is at most two short, then fix by remainder
	always_comb begin
		est_sum      = W'(prod) + W'(prod >> N);
		q_est        = est_sum[W-1:N];
		q_times_full = {q_est, {N{1'b0}}} - W'(q_est);
		rem          = W'(prod) - q_times_full;
		if (rem >= FULL2) begin
			quot = q_est + QW'(2);
		end else if (rem >= FULL1) begin
			quot = q_est + QW'(1);
		end else begin
			quot = q_est;
		end
	end

	// offset and clamp to the top of the range
	always_comb begin
		raw = jsm_pkg::PULSE_W'(quot) + jsm_pkg::PULSE_W'(lo);
		top = jsm_pkg::PULSE_W'(lo) + jsm_pkg::PULSE_W'(span);
		if (raw > top) begin
			pulse = top;
		end else begin
			pulse = raw;
		end
	end

endmodule

`default_nettype wire

// ===== sim/joystick_servo_mapper_tb.sv =====
`default_nettype none

module joystick_servo_mapper_tb;
	import jsm_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 160;
	localparam int LONG_HOLD     = 64;

	// addresses with no register behind them
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

	typedef enum int {
		PACE_FLOW,
		PACE_SRC_GAPS,
		PACE_SINK_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic               manual;
		logic               moved;
		logic [PULSE_W-1:0] px;
		logic [PULSE_W-1:0] py;
	} servo_report_t;

	typedef struct {
		logic                   fixed;
		logic                   op;
		logic [SAMPLE_BITS-1:0] sx;
		logic [SAMPLE_BITS-1:0] sy;
		servo_report_t          want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// sample_x, sample_y
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	// opcode
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// pulse_x, pulse_y
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	// manual_mode, moved
	logic [OUT_USER_W-1:0]  m_axis_tuser;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// mirror of the configuration registers
	logic [CFG_W-1:0]       noise_thr;
	logic [TIMEOUT_W-1:0]   idle_tmo;
	logic [CFG_W-1:0]       x_min;
	logic [CFG_W-1:0]       x_span;
	logic [CFG_W-1:0]       y_min;
	logic [CFG_W-1:0]       y_span;

	// mirror of the mapper state
	logic [SAMPLE_BITS-1:0] anchor_x;
	logic [SAMPLE_BITS-1:0] anchor_y;
	logic                   anchored;
	logic                   in_manual;
	logic [IDLE_W-1:0]      idle_ticks;
	logic [PULSE_W-1:0]     servo_x_now;
	logic [PULSE_W-1:0]     servo_y_now;

	servo_report_t          servo_reports_q[$];
	stim_row_t              directed_rows [13];

	int                     fail_count = 0;
	int                     cycle_count = 0;
	int                     src_gap_pct = 0;
	int                     sink_stall_pct = 0;
	int                     hold_req = 0;
	int                     hold_seen = 0;
	int                     sink_hold = 0;

	joystick_servo_mapper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("joystick_servo_mapper test failed");
			$finish;
		end
	end

	// pulse scaling with clamp at min + span
	function automatic logic [PULSE_W-1:0] map_pulse(input logic [SAMPLE_BITS-1:0] s,
		input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] span);
		int unsigned p;
		int unsigned top;
		p = (32'(s) * 32'(span)) / 32'(SAMPLE_FULL) + 32'(lo);
		top = 32'(lo) + 32'(span);
		if (p > top)
			p = top;
		return PULSE_W'(p);
	endfunction

	// one step of the mapper on an accepted transaction
	task automatic track_joystick(input logic op, input logic [SAMPLE_BITS-1:0] sx,
		input logic [SAMPLE_BITS-1:0] sy, output servo_report_t r);
		logic [SAMPLE_BITS-1:0] dx;
		logic [SAMPLE_BITS-1:0] dy;
		logic                   mx;
		logic                   my;
		r.moved = 1'b0;
		if (op == OP_SAMPLE) begin
			if (!anchored) begin
				anchor_x   = sx;
				anchor_y   = sy;
				anchored   = 1'b1;
				idle_ticks = '0;
			end else begin
				dx = (sx >= anchor_x) ? sx - anchor_x : anchor_x - sx;
				dy = (sy >= anchor_y) ? sy - anchor_y : anchor_y - sy;
				mx = dx > noise_thr;
				my = dy > noise_thr;
				if (mx || my) begin
					r.moved = 1'b1;
					if (mx)
						anchor_x = sx;
					if (my)
						anchor_y = sy;
					in_manual   = 1'b1;
					idle_ticks  = '0;
					servo_x_now = map_pulse(sx, x_min, x_span);
					servo_y_now = map_pulse(sy, y_min, y_span);
				end
			end
		end else if (in_manual) begin
			if (idle_ticks != IDLE_MAX)
				idle_ticks++;
			if (idle_ticks > idle_tmo)
				in_manual = 1'b0;
		end
		r.manual = in_manual;
		r.px     = servo_x_now;
		r.py     = servo_y_now;
	endtask

	// a sample value around the current reference, often right at the threshold
	function automatic logic [SAMPLE_BITS-1:0] near_anchor(input logic [SAMPLE_BITS-1:0] a);
		int off;
		int v;
		off = 0;
		case ($urandom_range(0, 5))
			0: return SAMPLE_BITS'($urandom);
			1: off = int'(noise_thr);
			2: off = int'(noise_thr) + 1;
			3: off = $urandom_range(0, int'(noise_thr));
			4: off = 0;
			default: off = int'(noise_thr) + $urandom_range(1, 300);
		endcase
		v = $urandom_range(0, 1) ? int'(a) + off : int'(a) - off;
		if (v < 0)
			v = 0;
		if (v > int'(SAMPLE_FULL))
			v = int'(SAMPLE_FULL);
		return SAMPLE_BITS'(v);
	endfunction

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_FLOW: begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			PACE_SRC_GAPS: begin
				src_gap_pct = 81;
				sink_stall_pct = 0;
			end
			PACE_SINK_STALLS: begin
				src_gap_pct = 0;
				sink_stall_pct = 81;
			end
			default: begin
				src_gap_pct = 26;
				sink_stall_pct = 26;
			end
		endcase
	endtask

	// called at a falling edge, leaves cfg_we high for the caller to drop
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_NOISE_THR: noise_thr = data[CFG_W-1:0];
			REG_IDLE_TMO:  idle_tmo  = data[TIMEOUT_W-1:0];
			REG_X_MIN:     x_min     = data[CFG_W-1:0];
			REG_X_SPAN:    x_span    = data[CFG_W-1:0];
			REG_Y_MIN:     y_min     = data[CFG_W-1:0];
			REG_Y_SPAN:    y_span    = data[CFG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] tmo,
		input logic [CFG_DATA_W-1:0] xlo, input logic [CFG_DATA_W-1:0] xsp,
		input logic [CFG_DATA_W-1:0] ylo, input logic [CFG_DATA_W-1:0] ysp);
		write_reg(REG_NOISE_THR, thr);
		write_reg(REG_IDLE_TMO, tmo);
		write_reg(REG_X_MIN, xlo);
		write_reg(REG_X_SPAN, xsp);
		write_reg(REG_Y_MIN, ylo);
		write_reg(REG_Y_SPAN, ysp);
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(input logic op, input logic [SAMPLE_BITS-1:0] sx,
		input logic [SAMPLE_BITS-1:0] sy, input logic fixed, input servo_report_t want);
		servo_report_t r;
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= IN_DATA_W'({sy, sx});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_joystick(op, sx, sy, r);
		servo_reports_q.push_back(fixed ? want : r);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		logic                   op;
		logic [SAMPLE_BITS-1:0] sx;
		logic [SAMPLE_BITS-1:0] sy;
		op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_SAMPLE;
		if (op == OP_TICK) begin
			sx = SAMPLE_BITS'($urandom);
			sy = SAMPLE_BITS'($urandom);
		end else begin
			sx = near_anchor(anchor_x);
			sy = near_anchor(anchor_y);
		end
		send_item(op, sx, sy, 1'b0, '0);
	endtask

	// let every result drain before touching the registers
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (servo_reports_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// receiver: random stalls plus a long hold-off whenever one is requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			sink_hold = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// result checking against the oldest pending report
	always @(posedge clk) begin
		servo_report_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (servo_reports_q.size() == 0) begin
				$error("result transaction with no report pending");
				fail_count++;
			end else begin
				w = servo_reports_q.pop_front();
				if (m_axis_tuser[0] !== w.manual) begin
					$error("manual_mode: expected %0d, got %0d", w.manual, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tuser[1] !== w.moved) begin
					$error("moved: expected %0d, got %0d", w.moved, m_axis_tuser[1]);
					fail_count++;
				end
				if (m_axis_tdata[PULSE_W-1:0] !== w.px) begin
					$error("pulse_x: expected %0d, got %0d", w.px, m_axis_tdata[PULSE_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[2*PULSE_W-1:PULSE_W] !== w.py) begin
					$error("pulse_y: expected %0d, got %0d", w.py,
						m_axis_tdata[2*PULSE_W-1:PULSE_W]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_SAMPLE;
		cfg_we        = 1'b0;
		cfg_addr      = REG_NOISE_THR;
		cfg_wdata     = '0;

		noise_thr   = NOISE_THR_RST;
		idle_tmo    = IDLE_TMO_RST;
		x_min       = X_MIN_RST;
		x_span      = X_SPAN_RST;
		y_min       = Y_MIN_RST;
		y_span      = Y_SPAN_RST;
		anchor_x    = '0;
		anchor_y    = '0;
		anchored    = 1'b0;
		in_manual   = 1'b0;
		idle_ticks  = '0;
		servo_x_now = SERVO_RST;
		servo_y_now = SERVO_RST;

		// directed items on the reset settings
		directed_rows = '{
			// ticks before priming, data ignored
			'{1'b1, OP_TICK,   12'd0,    12'd0,    '{1'b0, 1'b0, 13'd1500, 13'd1500}},
			'{1'b1, OP_TICK,   12'd4095, 12'd4095, '{1'b0, 1'b0, 13'd1500, 13'd1500}},
			// priming sample only loads the reference
			'{1'b1, OP_SAMPLE, 12'd0,    12'd0,    '{1'b0, 1'b0, 13'd1500, 13'd1500}},
			// difference equal to the threshold is not movement
			'{1'b1, OP_SAMPLE, 12'd200,  12'd200,  '{1'b0, 1'b0, 13'd1500, 13'd1500}},
			'{1'b0, OP_SAMPLE, 12'd201,  12'd0,    '0},
			// full scale on both axes
			'{1'b1, OP_SAMPLE, 12'd4095, 12'd4095, '{1'b1, 1'b1, 13'd2400, 13'd1450}},
			'{1'b1, OP_TICK,   12'd0,    12'd0,    '{1'b1, 1'b0, 13'd2400, 13'd1450}},
			'{1'b1, OP_SAMPLE, 12'd3895, 12'd3895, '{1'b1, 1'b0, 13'd2400, 13'd1450}},
			'{1'b0, OP_SAMPLE, 12'd4095, 12'd3894, '0},
			'{1'b0, OP_SAMPLE, 12'd0,    12'd4095, '0},
			'{1'b0, OP_TICK,   12'd4095, 12'd0,    '0},
			'{1'b0, OP_SAMPLE, 12'd2048, 12'd2048, '0},
			'{1'b0, OP_SAMPLE, 12'd2047, 12'd1365, '0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].sx, directed_rows[i].sy,
				directed_rows[i].fixed, directed_rows[i].want);

		// random phases over several settings and pacing patterns
		for (int ph = 0; ph < 9; ph++) begin
			wait_drained();
			case (ph)
				0: apply_settings(200, 5, 1300, 1100, 900, 550);
				1: apply_settings(0, 0, 0, 0, 0, 0);
				2: apply_settings(4095, 65535, 4095, 4095, 4095, 4095);
				3: apply_settings(1, 3, 4095, 4095, 0, 4095);
				4: apply_settings(50, 12, 0, 4095, 4095, 0);
				default: apply_settings(CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom_range(0, 40)),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			endcase
			set_pace(pace_t'(ph % 4));
			// long receiver hold-off while the sender keeps offering
			if (ph == 0)
				hold_req++;
			repeat (PHASE_ITEMS)
				send_random_item();
		end

		s_axis_tvalid <= 1'b0;
		while (servo_reports_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("joystick_servo_mapper test passed");
		else
			$display("joystick_servo_mapper test failed");
		$finish;
	end

endmodule

`default_nettype wire
